// ----- src/fpdf_pkg.sv -----
// ---------------------------------------------------------------------------
// fpdf_pkg: shared types and constants of the decimal text formatter
// Field widths, character codes, sequencer states and the cell control group.
// ---------------------------------------------------------------------------
package fpdf_pkg;

   localparam int VALUE_W      = 32;
   localparam int UNITS_W      = 4;
   localparam int DECS_W       = 4;
   localparam int POS_W        = 5;
   localparam int CHAR_W       = 8;
   localparam int DIGIT_W      = 4;
   localparam int NUM_DIGITS   = 10;
   localparam int DIG_IDX_W    = $clog2(NUM_DIGITS);
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 16;

   localparam int MAX_UNITS    = 10;
   localparam int MAX_DECIMALS = 10;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_UNITS,
      ST_POINT,
      ST_DECS,
      ST_TERM
   } state_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctl_type;

endpackage

// ----- src/fpdf_bcd_cell.sv -----
// ---------------------------------------------------------------------------
// fpdf_bcd_cell: one decimal digit of the shift-and-add-three chain
// Corrects its digit when five or more, shifts in the neighbor's bit and
// hands its top bit to the next cell up.
// ---------------------------------------------------------------------------
module fpdf_bcd_cell
   import fpdf_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic               carry_in,
   output logic               carry_out,
   output logic [DIGIT_W-1:0] digit
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] corr;

   assign corr      = (digit_ff >= DIGIT_W'(5)) ? digit_ff + DIGIT_W'(3) : digit_ff;
   assign carry_out = corr[DIGIT_W-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.shift) begin
         digit_in = {corr[DIGIT_W-2:0], carry_in};
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// ----- src/fixed_point_decimal_formatter.sv -----
// ---------------------------------------------------------------------------
// fixed_point_decimal_formatter: fixed-width decimal text of a 32-bit value
// The value is shifted bit by bit through the digit cell chain, then the
// characters go out through the output register, one character per cycle
// while the response side takes them.
// A new request is taken only in idle, once the last character of the
// previous run has gone into the single character output register.
// Reset: synchronous, clears the sequencer and the response valid; no sweep.
// ---------------------------------------------------------------------------
module fixed_point_decimal_formatter
   import fpdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // value[31:0], unit_digits[35:32], decimal_digits[39:36], no_point[40],
   // pad_spaces[41], null_terminate[42], zero[47:43]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // position[4:0], character[12:5], zero[15:13]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int CNT_W = $clog2(VALUE_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

   state_type state_ff, state_in;

   logic [VALUE_W-1:0]   val_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [UNITS_W-1:0]   units_ff, ucnt_ff;
   logic [DECS_W-1:0]    decs_ff, dcnt_ff;
   logic                 nopt_ff, pad_ff, term_ff, lead_ff;
   logic [POS_W-1:0]     pos_ff, didx_ff;
   logic                 rsp_valid_ff;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic [CHAR_W-1:0]    rsp_char_ff;
   logic                 rsp_last_ff;

   logic                 req_fire, emit_fire, out_free, emitting;
   logic [VALUE_W-1:0]   in_value;
   logic [UNITS_W-1:0]   in_units, units_clamp;
   logic [DECS_W-1:0]    in_decs, decs_clamp;
   logic                 in_nopt, in_pad, in_term;

   logic [DIGIT_W-1:0]   digits [NUM_DIGITS];
   logic [NUM_DIGITS-1:0] carry;
   cell_ctl_type         cell_ctl;
   logic [DIGIT_W-1:0]   cur_digit;
   logic [CHAR_W-1:0]    emit_char;
   logic                 emit_last, emit_space;

   assign in_value = req_tdata[31:0];
   assign in_units = req_tdata[35:32];
   assign in_decs  = req_tdata[39:36];
   assign in_nopt  = req_tdata[40];
   assign in_pad   = req_tdata[41];
   assign in_term  = req_tdata[42];

   always_comb begin
      units_clamp = in_units;
      if (in_units == '0) begin
         units_clamp = UNITS_W'(1);
      end else if (in_units > UNITS_W'(MAX_UNITS)) begin
         units_clamp = UNITS_W'(MAX_UNITS);
      end
      decs_clamp = in_decs;
      if (in_nopt) begin
         decs_clamp = '0;
      end else if (in_decs > DECS_W'(MAX_DECIMALS)) begin
         decs_clamp = DECS_W'(MAX_DECIMALS);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emitting   = (state_ff == ST_UNITS) || (state_ff == ST_POINT) ||
                       (state_ff == ST_DECS) || (state_ff == ST_TERM);
   assign emit_fire  = emitting && out_free;

   assign cell_ctl.clear = req_fire;
   assign cell_ctl.shift = (state_ff == ST_CONVERT);

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      fpdf_bcd_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .carry_in  ((i == 0) ? val_ff[VALUE_W-1] : carry[(i == 0) ? 0 : i-1]),
         .carry_out (carry[i]),
         .digit     (digits[i])
      );
   end

   assign cur_digit = (didx_ff < POS_W'(NUM_DIGITS)) ?
                      digits[didx_ff[DIG_IDX_W-1:0]] : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (cnt_ff == CNT_LAST) state_in = ST_UNITS;
         end
         ST_UNITS: begin
            if (emit_fire && ucnt_ff == UNITS_W'(1)) begin
               if (!nopt_ff)     state_in = ST_POINT;
               else if (term_ff) state_in = ST_TERM;
               else              state_in = ST_IDLE;
            end
         end
         ST_POINT: begin
            if (emit_fire) begin
               if (decs_ff != '0) state_in = ST_DECS;
               else if (term_ff)  state_in = ST_TERM;
               else               state_in = ST_IDLE;
            end
         end
         ST_DECS: begin
            if (emit_fire && dcnt_ff == DECS_W'(1)) begin
               state_in = term_ff ? ST_TERM : ST_IDLE;
            end
         end
         ST_TERM: begin
            if (emit_fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      emit_char  = CH_NUL;
      emit_last  = 1'b0;
      emit_space = 1'b0;
      case (state_ff)
         ST_UNITS: begin
            emit_space = pad_ff && lead_ff && (ucnt_ff > UNITS_W'(1)) &&
                         (cur_digit == '0);
            emit_char  = emit_space ? CH_SPACE : CH_ZERO + CHAR_W'(cur_digit);
            emit_last  = (ucnt_ff == UNITS_W'(1)) && nopt_ff && !term_ff;
         end
         ST_POINT: begin
            emit_char = CH_POINT;
            emit_last = (decs_ff == '0) && !term_ff;
         end
         ST_DECS: begin
            emit_char = CH_ZERO + CHAR_W'(cur_digit);
            emit_last = (dcnt_ff == DECS_W'(1)) && !term_ff;
         end
         ST_TERM: begin
            emit_char = CH_NUL;
            emit_last = 1'b1;
         end
         default: begin
            emit_char = CH_NUL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         val_ff   <= in_value;
         cnt_ff   <= '0;
         units_ff <= units_clamp;
         decs_ff  <= decs_clamp;
         nopt_ff  <= in_nopt;
         pad_ff   <= in_pad;
         term_ff  <= in_term;
      end else if (state_ff == ST_CONVERT) begin
         val_ff <= {val_ff[VALUE_W-2:0], 1'b0};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (state_ff == ST_CONVERT && cnt_ff == CNT_LAST) begin
         ucnt_ff <= units_ff;
         dcnt_ff <= decs_ff;
         didx_ff <= POS_W'(units_ff) + POS_W'(decs_ff) - POS_W'(1);
         pos_ff  <= '0;
         lead_ff <= 1'b1;
      end else if (emit_fire) begin
         pos_ff <= pos_ff + POS_W'(1);
         if (state_ff == ST_UNITS) begin
            ucnt_ff <= ucnt_ff - UNITS_W'(1);
            didx_ff <= didx_ff - POS_W'(1);
            lead_ff <= emit_space;
         end
         if (state_ff == ST_DECS) begin
            dcnt_ff <= dcnt_ff - DECS_W'(1);
            didx_ff <= didx_ff - POS_W'(1);
         end
      end
      if (emit_fire) begin
         rsp_pos_ff  <= pos_ff;
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - POS_W - CHAR_W)'(0), rsp_char_ff, rsp_pos_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/fpdf_checker.sv -----
// ---------------------------------------------------------------------------
// fpdf_checker: port-level checks of the decimal text formatter
// Watches the request and response channels and flags broken runs.
// ---------------------------------------------------------------------------
module fpdf_checker
   import fpdf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a run is in progress");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:0] <= 5'd21 && rsp_tdata[15:13] == 3'd0)
      else $error("response position out of range");

   a_first_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4:0] == 5'd0 |->
         rsp_tdata[12:5] != CH_POINT && rsp_tdata[12:5] != CH_NUL)
      else $error("run does not open with a digit or space");

   a_next_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid |->
         rsp_tdata[4:0] == $past(rsp_tdata[4:0]) + 5'd1)
      else $error("response positions not consecutive");

endmodule

bind fixed_point_decimal_formatter fpdf_checker u_fpdf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
